[rtl/fcr_pkg.sv]
// fcr_pkg: shared constants, codes and types of the FIR convolution reverb.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package fcr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int INDEX_BITS  = 10;
  localparam int FRAC_BITS   = 15;
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;

  // floor(n / 3) == (n * 43691) >> 17 for 0 <= n < 2**17
  localparam int              DIV3_BITS  = 17;
  localparam logic [16:0]     DIV3_RECIP = 17'd43691;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } mac_ctl_t;

endpackage
`default_nettype wire

[rtl/fcr_if.sv]
// fcr_in_if / fcr_out_if: valid/ready channels of the reverb block.
// Depends on fcr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fcr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic signed [fcr_pkg::SAMPLE_BITS-1:0] sample_in;
  logic        [fcr_pkg::INDEX_BITS-1:0]  coef_index;
  logic signed [fcr_pkg::COEF_BITS-1:0]   coef_value;

  modport source (output valid, kind, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, kind, sample_in, coef_index, coef_value, output ready);
endinterface

interface fcr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fcr_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                 clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface
`default_nettype wire

[rtl/fcr_mac.sv]
// fcr_mac: registered multiplier, accumulator and scale/saturate of the FIR sum.
// Depends on fcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcr_mac #(
  parameter int ACC_W = 42
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire fcr_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [fcr_pkg::COEF_BITS-1:0]   coef,
  input  wire logic signed [fcr_pkg::SAMPLE_BITS-1:0] data,
  output logic                                   busy,
  output logic signed [fcr_pkg::SAMPLE_BITS-1:0] y,
  output logic                                   clip
);

  localparam int SB = fcr_pkg::SAMPLE_BITS;

  logic signed [fcr_pkg::PROD_BITS-1:0] prod;
  logic                                 pvld;
  logic signed [ACC_W-1:0]              acc;
  logic signed [ACC_W-1:0]              scaled;
  logic        [ACC_W-SB:0]             upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
    end else begin
      pvld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prod <= coef * data;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (pvld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy   = pvld;
  assign scaled = acc >>> fcr_pkg::FRAC_BITS;
  assign upper  = scaled[ACC_W-1:SB-1];
  assign clip   = !((&upper) || (~|upper));

  always_comb begin
    if (!clip) begin
      y = scaled[SB-1:0];
    end else if (scaled[ACC_W-1]) begin
      y = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y = {1'b0, {(SB-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

[rtl/fir_convolution_reverb_top.sv]
// fir_convolution_reverb_top: direct-form FIR reverb over a coefficient RAM and a
// circular delay-line RAM with one shared MAC. Depends on fcr_pkg, fcr_if, fcr_mac.
//
//   port   dir   beat contents
//   din    in    kind, sample_in, coef_index, coef_value
//   dout   out   sample_out, clipped (one beat per sample beat)
//
// Load beat: coefficient written on acceptance.
// Sample beat: the MAC reads one tap per cycle from both RAMs.
// din.ready is low while a sample is in work; a held result does not block din.
// Reset: synchronous; the delay line reads as zero until each slot is written
// (fill count), so no clearing pass is needed. Coefficients must be loaded first.
`timescale 1ns / 1ps
`default_nettype none
module fir_convolution_reverb_top #(
  parameter int TAPS = 1024
) (
  input  wire       clk,
  input  wire       rst,
  fcr_in_if.sink    din,
  fcr_out_if.source dout
);

  localparam int SB     = fcr_pkg::SAMPLE_BITS;
  localparam int AW     = $clog2(TAPS);
  localparam int FILL_W = $clog2(TAPS + 1);
  localparam int ACC_W  = fcr_pkg::PROD_BITS + AW;
  localparam int DW     = fcr_pkg::DIV3_BITS;

  fcr_pkg::state_t state, state_next;

  logic [AW-1:0]     wpos;
  logic [AW-1:0]     rpos;
  logic [AW-1:0]     kcnt;
  logic [FILL_W-1:0] fill;
  logic              p1;
  logic              dvld_q;
  logic signed [SB-1:0] sample_q;

  logic signed [fcr_pkg::COEF_BITS-1:0] coef_mem [TAPS];
  logic signed [SB-1:0]                 dly_mem  [TAPS];
  logic signed [fcr_pkg::COEF_BITS-1:0] coef_rd;
  logic signed [SB-1:0]                 dly_rd;

  logic in_fire;
  logic coef_we;
  logic issue;
  logic out_load;
  logic tap_valid;

  logic [DW-1:0]     mag;
  logic [2*DW-1:0]   quot_full;
  logic [DW-1:0]     quot;
  logic signed [SB-1:0] div3;

  fcr_pkg::mac_ctl_t    mac_ctl;
  logic                 mac_busy;
  logic signed [SB-1:0] mac_y;
  logic                 mac_clip;
  logic signed [SB-1:0] mac_data;

  logic                 out_valid;
  logic signed [SB-1:0] out_sample;
  logic                 out_clip;

  assign in_fire = din.valid && din.ready;
  assign coef_we = in_fire && (din.kind == fcr_pkg::KIND_LOAD)
                   && (32'(din.coef_index) < TAPS);

  // divide by 3, truncating toward zero
  assign mag       = sample_q[SB-1] ? (DW'(0) - DW'(sample_q)) : DW'(sample_q);
  assign quot_full = (2*DW)'(mag) * (2*DW)'(fcr_pkg::DIV3_RECIP);
  assign quot      = quot_full[2*DW-1:DW];
  assign div3      = sample_q[SB-1] ? (SB'(0) - SB'(quot)) : SB'(quot);

  assign tap_valid = (fill == FILL_W'(TAPS)) || (FILL_W'(rpos) < fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    din.ready  = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      fcr_pkg::ST_IDLE: begin
        din.ready = 1'b1;
        if (din.valid && (din.kind == fcr_pkg::KIND_SAMPLE)) begin
          state_next = fcr_pkg::ST_WRITE;
        end
      end
      fcr_pkg::ST_WRITE: begin
        state_next = fcr_pkg::ST_RUN;
      end
      fcr_pkg::ST_RUN: begin
        issue = 1'b1;
        if (kcnt == AW'(TAPS - 1)) begin
          state_next = fcr_pkg::ST_DRAIN;
        end
      end
      fcr_pkg::ST_DRAIN: begin
        if (!p1 && !mac_busy) begin
          state_next = fcr_pkg::ST_FINISH;
        end
      end
      fcr_pkg::ST_FINISH: begin
        if (!out_valid || dout.ready) begin
          out_load   = 1'b1;
          state_next = fcr_pkg::ST_IDLE;
        end
      end
      default: state_next = fcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
      fill <= '0;
      p1   <= 1'b0;
    end else begin
      p1 <= issue;
      if (state == fcr_pkg::ST_WRITE) begin
        wpos <= (wpos == AW'(TAPS - 1)) ? '0 : wpos + AW'(1);
        if (fill != FILL_W'(TAPS)) begin
          fill <= fill + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_q <= din.sample_in;
    end
    if (state == fcr_pkg::ST_WRITE) begin
      rpos <= wpos;
      kcnt <= '0;
    end else if (issue) begin
      rpos <= (rpos == '0) ? AW'(TAPS - 1) : rpos - AW'(1);
      kcnt <= kcnt + AW'(1);
    end
    if (issue) begin
      dvld_q <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[AW'(din.coef_index)] <= din.coef_value;
    end
    coef_rd <= coef_mem[kcnt];
  end

  always_ff @(posedge clk) begin
    if (state == fcr_pkg::ST_WRITE) begin
      dly_mem[wpos] <= div3;
    end
    dly_rd <= dly_mem[rpos];
  end

  assign mac_ctl.clear = (state == fcr_pkg::ST_WRITE);
  assign mac_ctl.vld   = p1;
  assign mac_data      = dvld_q ? dly_rd : '0;

  fcr_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .coef (coef_rd),
    .data (mac_data),
    .busy (mac_busy),
    .y    (mac_y),
    .clip (mac_clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= mac_y;
      out_clip   <= mac_clip;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;
  assign dout.clipped    = out_clip;

endmodule
`default_nettype wire

[rtl/fcr_checker.sv]
// fcr_props: port-level assertions of the reverb block, bound to the top level.
// Depends on fcr_pkg and fir_convolution_reverb_top.
`timescale 1ns / 1ps
`default_nettype none
module fcr_props (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               in_kind,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [fcr_pkg::SAMPLE_BITS-1:0]    out_sample,
  input wire                               out_clipped
);

  localparam logic [fcr_pkg::SAMPLE_BITS-1:0] POS_MAX =
    {1'b0, {(fcr_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic [fcr_pkg::SAMPLE_BITS-1:0] NEG_MIN =
    {1'b1, {(fcr_pkg::SAMPLE_BITS-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clipped))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == fcr_pkg::KIND_LOAD) && !out_valid |=> !out_valid)
    else $error("load beat produced a result");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == fcr_pkg::KIND_SAMPLE) |=> !in_ready)
    else $error("input ready while sample in work");

  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_clipped |-> (out_sample == POS_MAX) || (out_sample == NEG_MIN))
    else $error("clipped result not at a bound");

endmodule

bind fir_convolution_reverb_top fcr_props u_fcr_props (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (din.valid),
  .in_ready    (din.ready),
  .in_kind     (din.kind),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .out_sample  (dout.sample_out),
  .out_clipped (dout.clipped)
);
`default_nettype wire
